// File: design/rpn_stack_calculator_defines.svh
// assertion macros shared by the calculator's checker
// no dependencies; each macro expects clk and rst_n in scope
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// implication within the same cycle
`define RPN_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpn check failed");

// implication on the following cycle
`define RPN_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpn check failed");

`endif

// File: design/rpn_pkg.sv
// types, codes and constants for the rpn stack calculator
// no dependencies; used by every module of the block
package rpn_pkg;

  localparam int WORD_W          = 32;
  localparam int PV_W            = 31;
  localparam int REQ_W           = 3;
  localparam int STS_W           = 3;
  localparam int STACK_DEPTH_DEF = 32;
  localparam int DIV_STEP_W      = $clog2(WORD_W);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 3'd0,
    REQ_ADD   = 3'd1,
    REQ_SUB   = 3'd2,
    REQ_MUL   = 3'd3,
    REQ_DIV   = 3'd4,
    REQ_PEEK  = 3'd5,
    REQ_DUMP  = 3'd6,
    REQ_CLEAR = 3'd7
  } rpn_req_t;

  typedef enum logic [STS_W-1:0] {
    STS_DONE  = 3'd0,
    STS_VALUE = 3'd1,
    STS_FEW   = 3'd2,
    STS_EMPTY = 3'd3,
    STS_DIV0  = 3'd4,
    STS_FULL  = 3'd5
  } rpn_sts_t;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_SEC,
    RD_NEXT
  } rpn_rdsel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_OP_T,
    S_OP_S,
    S_EXEC,
    S_DIV,
    S_WB,
    S_CAP,
    S_EMIT
  } rpn_state_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [PV_W-1:0]  push_value;
  } rpn_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic [STS_W-1:0]         status;
    logic                     last;
  } rpn_out_t;

  // controller to datapath
  typedef struct packed {
    logic       capture_in;
    logic       rd_en;
    rpn_rdsel_t rd_sel;
    logic       cap_t;
    logic       cap_s;
    logic       alu_load;
    logic       div_start;
    logic       div_load;
    logic       wb;
    logic       push;
    logic       clear;
    logic       idx_load;
    logic       idx_dec;
    logic       res_load;
    rpn_sts_t   res_status;
    logic       res_from_mem;
    logic       res_last;
    logic       out_load;
  } rpn_cmd_t;

  // datapath to controller
  typedef struct packed {
    rpn_req_t req;
    logic     cnt_zero;
    logic     cnt_full;
    logic     cnt_lt2;
    logic     t_zero;
    logic     idx_zero;
    logic     div_done;
    logic     out_free;
  } rpn_stat_t;

endpackage

// File: design/rpn_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
// depends on rpn_pkg
module rpn_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rpn_pkg::WORD_W-1:0]  dividend,
  input  logic [rpn_pkg::WORD_W-1:0]  divisor,
  output logic                        done,
  output logic [rpn_pkg::WORD_W-1:0]  quotient
);

  logic                             busy_r;
  logic                             done_r;
  logic [rpn_pkg::DIV_STEP_W-1:0]   step_r;
  logic [rpn_pkg::WORD_W-1:0]       rem_r;
  logic [rpn_pkg::WORD_W-1:0]       quo_r;
  logic [rpn_pkg::WORD_W-1:0]       dvs_r;
  logic                             neg_r;

  logic [rpn_pkg::WORD_W:0]         rem_sh;
  logic [rpn_pkg::WORD_W:0]         diff;
  logic                             ge;
  logic                             na;
  logic                             nb;

  assign na = dividend[rpn_pkg::WORD_W-1];
  assign nb = divisor[rpn_pkg::WORD_W-1];

  always_comb begin
    rem_sh = {rem_r, quo_r[rpn_pkg::WORD_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    ge     = !diff[rpn_pkg::WORD_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == rpn_pkg::DIV_STEP_W'(rpn_pkg::WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // magnitudes in, sign restored on the way out
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= na ? (~dividend + 1'b1) : dividend;
      dvs_r <= nb ? (~divisor + 1'b1) : divisor;
      neg_r <= na ^ nb;
    end else if (busy_r) begin
      rem_r <= ge ? diff[rpn_pkg::WORD_W-1:0] : rem_sh[rpn_pkg::WORD_W-1:0];
      quo_r <= {quo_r[rpn_pkg::WORD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// File: design/rpn_datapath.sv
// datapath: stack memory, entry count, operand registers, alu and output register
// depends on rpn_pkg and rpn_div
module rpn_datapath #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rpn_pkg::rpn_in_t  in_data,
  input  rpn_pkg::rpn_cmd_t cmd,
  output rpn_pkg::rpn_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output rpn_pkg::rpn_out_t out_data
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  logic [rpn_pkg::WORD_W-1:0] mem [STACK_DEPTH];

  logic [CNT_W-1:0]            cnt_r;
  rpn_pkg::rpn_req_t           req_r;
  logic [rpn_pkg::PV_W-1:0]    pv_r;
  logic [ADDR_W-1:0]           idx_r;
  logic [rpn_pkg::WORD_W-1:0]  t_r;
  logic [rpn_pkg::WORD_W-1:0]  s_r;
  logic [rpn_pkg::WORD_W-1:0]  r_r;
  logic [rpn_pkg::WORD_W-1:0]  rd_data_r;
  rpn_pkg::rpn_out_t           res_r;
  logic                        out_valid_r;
  rpn_pkg::rpn_out_t           out_data_r;

  logic [CNT_W-1:0]            cnt_dec1;
  logic [CNT_W-1:0]            cnt_dec2;
  logic [ADDR_W-1:0]           rd_addr;
  logic [ADDR_W-1:0]           wr_addr;
  logic [rpn_pkg::WORD_W-1:0]  wr_data;
  logic                        wr_en;
  logic [rpn_pkg::WORD_W-1:0]  alu;
  logic                        div_done;
  logic [rpn_pkg::WORD_W-1:0]  div_q;

  assign cnt_dec1 = cnt_r - CNT_W'(1);
  assign cnt_dec2 = cnt_r - CNT_W'(2);

  always_comb begin
    unique case (cmd.rd_sel)
      rpn_pkg::RD_TOP:  rd_addr = cnt_dec1[ADDR_W-1:0];
      rpn_pkg::RD_SEC:  rd_addr = cnt_dec2[ADDR_W-1:0];
      rpn_pkg::RD_NEXT: rd_addr = idx_r - 1'b1;
      default:          rd_addr = idx_r;
    endcase
  end

  // push writes the slot above the top, write-back lands on the second entry
  assign wr_en   = cmd.push | cmd.wb;
  assign wr_addr = cmd.push ? cnt_r[ADDR_W-1:0] : cnt_dec2[ADDR_W-1:0];
  assign wr_data = cmd.push ? {1'b0, pv_r} : r_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // product kept to the low word, wrapping like the other operations
  always_comb begin
    unique case (req_r)
      rpn_pkg::REQ_SUB: alu = s_r - t_r;
      rpn_pkg::REQ_MUL: alu = s_r * t_r;
      default:          alu = s_r + t_r;
    endcase
  end

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (s_r),
    .divisor  (t_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cnt_r <= '0;
      end else if (cmd.push) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.wb) begin
        cnt_r <= cnt_dec1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_in) begin
      req_r <= rpn_pkg::rpn_req_t'(in_data.req_type);
      pv_r  <= in_data.push_value;
    end
    if (cmd.cap_t) begin
      t_r <= rd_data_r;
    end
    if (cmd.cap_s) begin
      s_r <= rd_data_r;
    end
    if (cmd.alu_load) begin
      r_r <= alu;
    end else if (cmd.div_load) begin
      r_r <= div_q;
    end
    if (cmd.idx_load) begin
      idx_r <= cnt_dec1[ADDR_W-1:0];
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - 1'b1;
    end
    if (cmd.res_load) begin
      res_r.result_value <= cmd.res_from_mem ? $signed(rd_data_r) : '0;
      res_r.status       <= cmd.res_status;
      res_r.last         <= cmd.res_last;
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  always_comb begin
    stat.req      = req_r;
    stat.cnt_zero = (cnt_r == '0);
    stat.cnt_full = (cnt_r == CNT_W'(STACK_DEPTH));
    stat.cnt_lt2  = (cnt_r < CNT_W'(2));
    stat.t_zero   = (t_r == '0);
    stat.idx_zero = (idx_r == '0);
    stat.div_done = div_done;
    stat.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/rpn_ctrl.sv
// controller state machine: sequences decode, operand reads, execute and output words
// depends on rpn_pkg
module rpn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpn_pkg::rpn_stat_t stat,
  output rpn_pkg::rpn_cmd_t  cmd
);

  rpn_pkg::rpn_state_t state_r;
  rpn_pkg::rpn_state_t state_nxt;
  logic                more_r;
  logic                more_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpn_pkg::S_IDLE;
      more_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      more_r  <= more_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    more_nxt  = more_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      rpn_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture_in = 1'b1;
          state_nxt      = rpn_pkg::S_DECODE;
        end
      end
      rpn_pkg::S_DECODE: begin
        cmd.res_last = 1'b1;
        unique case (stat.req)
          rpn_pkg::REQ_PUSH: begin
            cmd.res_load = 1'b1;
            if (stat.cnt_full) begin
              cmd.res_status = rpn_pkg::STS_FULL;
            end else begin
              cmd.push       = 1'b1;
              cmd.res_status = rpn_pkg::STS_DONE;
            end
            state_nxt = rpn_pkg::S_EMIT;
          end
          rpn_pkg::REQ_ADD, rpn_pkg::REQ_SUB, rpn_pkg::REQ_MUL, rpn_pkg::REQ_DIV: begin
            if (stat.cnt_lt2) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = rpn_pkg::STS_FEW;
              state_nxt      = rpn_pkg::S_EMIT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = rpn_pkg::RD_TOP;
              state_nxt  = rpn_pkg::S_OP_T;
            end
          end
          rpn_pkg::REQ_PEEK, rpn_pkg::REQ_DUMP: begin
            if (stat.cnt_zero) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = rpn_pkg::STS_EMPTY;
              state_nxt      = rpn_pkg::S_EMIT;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = rpn_pkg::RD_TOP;
              cmd.idx_load = 1'b1;
              state_nxt    = rpn_pkg::S_CAP;
            end
          end
          default: begin
            cmd.clear      = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = rpn_pkg::STS_DONE;
            state_nxt      = rpn_pkg::S_EMIT;
          end
        endcase
      end
      rpn_pkg::S_OP_T: begin
        cmd.cap_t  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = rpn_pkg::RD_SEC;
        state_nxt  = rpn_pkg::S_OP_S;
      end
      rpn_pkg::S_OP_S: begin
        cmd.cap_s = 1'b1;
        state_nxt = rpn_pkg::S_EXEC;
      end
      rpn_pkg::S_EXEC: begin
        if (stat.req == rpn_pkg::REQ_DIV) begin
          if (stat.t_zero) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = rpn_pkg::STS_DIV0;
            cmd.res_last   = 1'b1;
            state_nxt      = rpn_pkg::S_EMIT;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = rpn_pkg::S_DIV;
          end
        end else begin
          cmd.alu_load = 1'b1;
          state_nxt    = rpn_pkg::S_WB;
        end
      end
      rpn_pkg::S_DIV: begin
        if (stat.div_done) begin
          cmd.div_load = 1'b1;
          state_nxt    = rpn_pkg::S_WB;
        end
      end
      rpn_pkg::S_WB: begin
        cmd.wb         = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = rpn_pkg::STS_DONE;
        cmd.res_last   = 1'b1;
        state_nxt      = rpn_pkg::S_EMIT;
      end
      rpn_pkg::S_CAP: begin
        // peek gives one word; dump walks down until the bottom entry
        cmd.res_load     = 1'b1;
        cmd.res_from_mem = 1'b1;
        cmd.res_status   = rpn_pkg::STS_VALUE;
        cmd.res_last     = (stat.req != rpn_pkg::REQ_DUMP) || stat.idx_zero;
        more_nxt         = (stat.req == rpn_pkg::REQ_DUMP) && !stat.idx_zero;
        state_nxt        = rpn_pkg::S_EMIT;
      end
      rpn_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (more_r) begin
            cmd.idx_dec = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = rpn_pkg::RD_NEXT;
            state_nxt   = rpn_pkg::S_CAP;
          end else begin
            state_nxt = rpn_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = rpn_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: design/rpn_stack_calculator.sv
// rpn stack calculator top level: one command word in, one or more result words out.
// push, clear and too-few/empty/full results go from decode straight to the output word;
// peek reads the top entry; arithmetic reads both operands, divide by zero stops at execute,
// divide waits for the divider before write-back. dump gives its words one at a time, top first;
// the next command is taken the cycle after the last word is loaded out.
// reset (rst_n, synchronous) empties the stack; stack memory contents are not cleared.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpn_pkg::rpn_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rpn_pkg::rpn_out_t out_data
);

  rpn_pkg::rpn_cmd_t  cmd;
  rpn_pkg::rpn_stat_t stat;

  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpn_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: design/rpn_checker.sv
// port-level checks for the rpn stack calculator, bound to the top level
// depends on rpn_pkg and rpn_stack_calculator_defines.svh
`include "rpn_stack_calculator_defines.svh"

module rpn_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input rpn_pkg::rpn_out_t out_data
);

  // a stalled result word holds
  `RPN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // one command at a time: no second word taken straight after one
  `RPN_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `RPN_ASSERT_SAME(a_status_code, out_valid, out_data.status <= rpn_pkg::STS_FULL)
  // only value words carry data, and only a dump gives non-final words
  `RPN_ASSERT_SAME(a_zero_value, out_valid && (out_data.status != rpn_pkg::STS_VALUE), out_data.result_value == 0)
  `RPN_ASSERT_SAME(a_last_set, out_valid && (out_data.status != rpn_pkg::STS_VALUE), out_data.last)

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for rpn_stack_calculator: directed then random command words,
// results predicted by a stack mirror and checked word by word; depends on rpn_pkg
module testbench;

  localparam int STK_N       = rpn_pkg::STACK_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN       = 100;
  localparam int TAIL_WORDS  = 30;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  rpn_pkg::rpn_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  rpn_pkg::rpn_out_t out_data;

  rpn_pkg::rpn_in_t  pending_words [$];
  rpn_pkg::rpn_out_t results_due [$];
  logic [31:0]       stack_mirror [STK_N];
  int unsigned       mirror_depth = 0;
  int unsigned       fails = 0;
  int unsigned       cycle_count = 0;
  logic              in_hs = 1'b0;
  bit                idle_on = 1'b1;
  int unsigned       send_gap = 0;
  int unsigned       recv_stall = 0;
  rpn_pkg::rpn_out_t want;

  rpn_stack_calculator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void add_due(input logic [31:0] val, input rpn_pkg::rpn_sts_t sts,
                                  input logic fin);
    rpn_pkg::rpn_out_t w;
    w.result_value = val;
    w.status       = sts;
    w.last         = fin;
    results_due.push_back(w);
  endfunction

  // works out the result words of one accepted command and updates the mirror
  function automatic void calc_step(input rpn_pkg::rpn_in_t w);
    rpn_pkg::rpn_req_t req;
    logic [31:0]       top_w, sec_w, res_w, mag_s, mag_t, quo;
    int unsigned       k;
    req = rpn_pkg::rpn_req_t'(w.req_type);
    case (req)
      rpn_pkg::REQ_PUSH: begin
        if (mirror_depth >= STK_N) begin
          add_due('0, rpn_pkg::STS_FULL, 1'b1);
        end else begin
          stack_mirror[mirror_depth] = {1'b0, w.push_value};
          mirror_depth++;
          add_due('0, rpn_pkg::STS_DONE, 1'b1);
        end
      end
      rpn_pkg::REQ_ADD, rpn_pkg::REQ_SUB, rpn_pkg::REQ_MUL, rpn_pkg::REQ_DIV: begin
        if (mirror_depth < 2) begin
          add_due('0, rpn_pkg::STS_FEW, 1'b1);
        end else begin
          top_w = stack_mirror[mirror_depth-1];
          sec_w = stack_mirror[mirror_depth-2];
          if (req == rpn_pkg::REQ_DIV && top_w == '0) begin
            add_due('0, rpn_pkg::STS_DIV0, 1'b1);
          end else begin
            case (req)
              rpn_pkg::REQ_ADD: res_w = sec_w + top_w;
              rpn_pkg::REQ_SUB: res_w = sec_w - top_w;
              rpn_pkg::REQ_MUL: res_w = sec_w * top_w;
              default: begin
                // divide on magnitudes so the most negative word wraps cleanly
                mag_s = sec_w[31] ? -sec_w : sec_w;
                mag_t = top_w[31] ? -top_w : top_w;
                quo   = mag_s / mag_t;
                res_w = (sec_w[31] ^ top_w[31]) ? -quo : quo;
              end
            endcase
            mirror_depth--;
            stack_mirror[mirror_depth-1] = res_w;
            add_due('0, rpn_pkg::STS_DONE, 1'b1);
          end
        end
      end
      rpn_pkg::REQ_PEEK: begin
        if (mirror_depth == 0) add_due('0, rpn_pkg::STS_EMPTY, 1'b1);
        else add_due(stack_mirror[mirror_depth-1], rpn_pkg::STS_VALUE, 1'b1);
      end
      rpn_pkg::REQ_DUMP: begin
        if (mirror_depth == 0) begin
          add_due('0, rpn_pkg::STS_EMPTY, 1'b1);
        end else begin
          for (k = mirror_depth; k > 0; k--) begin
            add_due(stack_mirror[k-1], rpn_pkg::STS_VALUE, k == 1);
          end
        end
      end
      default: begin
        mirror_depth = 0;
        add_due('0, rpn_pkg::STS_DONE, 1'b1);
      end
    endcase
  endfunction

  function automatic void queue_command(input rpn_pkg::rpn_req_t req,
                                        input logic [rpn_pkg::PV_W-1:0] val);
    rpn_pkg::rpn_in_t w;
    w.req_type   = req;
    w.push_value = val;
    pending_words.push_back(w);
  endfunction

  function automatic logic [rpn_pkg::PV_W-1:0] pick_value();
    logic [rpn_pkg::PV_W-1:0] v;
    logic [31:0]              r;
    case ($urandom_range(0, 3))
      0: r = $urandom_range(0, 3);
      1: r = $urandom();
      2: r = $urandom_range(0, 1) ? '1 : '0;
      default: r = $urandom_range(0, 65535);
    endcase
    v = r[rpn_pkg::PV_W-1:0];
    return v;
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) idle_on = !idle_on;
      if (!(in_valid && !in_hs)) begin
        if (send_gap == 0 && idle_on && pending_words.size() > TAIL_WORDS &&
            $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 17);
        end
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (idle_on && pending_words.size() > TAIL_WORDS &&
                   $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: handshakes sampled on the rising edge
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else if (!rst_n) begin
      in_hs <= 1'b0;
    end else begin
      in_hs <= in_valid && in_ready;
      if (in_valid && in_ready) calc_step(in_data);
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result word with none expected: result_value %0d status %0d last %0d",
                 $signed(out_data.result_value), out_data.status, out_data.last);
          fails++;
        end else begin
          want = results_due.pop_front();
          if (out_data.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d",
                   $signed(want.result_value), $signed(out_data.result_value));
            fails++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fails++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            fails++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned       n_push, n_ops, seq_no;
    rpn_pkg::rpn_req_t op;

    // empty-stack, too-few-operand and divide-by-zero cases
    queue_command(rpn_pkg::REQ_PEEK, '1);
    queue_command(rpn_pkg::REQ_DUMP, '0);
    queue_command(rpn_pkg::REQ_ADD, '0);
    queue_command(rpn_pkg::REQ_PUSH, '1);
    queue_command(rpn_pkg::REQ_SUB, '0);
    queue_command(rpn_pkg::REQ_PUSH, '0);
    queue_command(rpn_pkg::REQ_DIV, '1);
    queue_command(rpn_pkg::REQ_DUMP, '0);
    queue_command(rpn_pkg::REQ_MUL, '0);
    queue_command(rpn_pkg::REQ_CLEAR, '1);
    // build the most negative word, then divide it by minus one
    queue_command(rpn_pkg::REQ_PUSH, 31'h4000_0000);
    queue_command(rpn_pkg::REQ_PUSH, 31'd2);
    queue_command(rpn_pkg::REQ_MUL, '0);
    queue_command(rpn_pkg::REQ_PUSH, 31'd0);
    queue_command(rpn_pkg::REQ_PUSH, 31'd1);
    queue_command(rpn_pkg::REQ_SUB, '0);
    queue_command(rpn_pkg::REQ_DIV, '0);
    queue_command(rpn_pkg::REQ_PEEK, '0);
    // negative over positive truncates toward zero
    queue_command(rpn_pkg::REQ_PUSH, 31'd7);
    queue_command(rpn_pkg::REQ_DIV, '0);
    queue_command(rpn_pkg::REQ_PUSH, 31'd3);
    queue_command(rpn_pkg::REQ_DIV, '0);
    queue_command(rpn_pkg::REQ_PUSH, '1);
    queue_command(rpn_pkg::REQ_ADD, '0);
    queue_command(rpn_pkg::REQ_DUMP, '0);
    queue_command(rpn_pkg::REQ_CLEAR, '0);

    seq_no = 0;
    while (pending_words.size() < 272) begin
      if (seq_no == 3 || $urandom_range(0, 11) == 0) begin
        // fill to the top, overflow, then read it all back
        queue_command(rpn_pkg::REQ_CLEAR, pick_value());
        repeat (STK_N + $urandom_range(1, 2)) queue_command(rpn_pkg::REQ_PUSH, pick_value());
        if ($urandom_range(0, 1)) queue_command(rpn_pkg::REQ_PEEK, pick_value());
        queue_command(rpn_pkg::REQ_DUMP, pick_value());
        op = rpn_pkg::rpn_req_t'($urandom_range(int'(rpn_pkg::REQ_ADD),
                                                int'(rpn_pkg::REQ_DIV)));
        queue_command(op, pick_value());
        queue_command(rpn_pkg::REQ_CLEAR, pick_value());
      end else if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          queue_command(rpn_pkg::rpn_req_t'($urandom_range(0, 7)), pick_value());
        end
      end else begin
        if ($urandom_range(0, 2) == 0) queue_command(rpn_pkg::REQ_CLEAR, pick_value());
        n_push = $urandom_range(1, 6);
        n_ops  = $urandom_range(1, 6);
        repeat (n_push) queue_command(rpn_pkg::REQ_PUSH, pick_value());
        repeat (n_ops) begin
          op = rpn_pkg::rpn_req_t'($urandom_range(int'(rpn_pkg::REQ_ADD),
                                                  int'(rpn_pkg::REQ_DUMP)));
          queue_command(op, pick_value());
        end
      end
      seq_no++;
    end

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(negedge clk);
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fails == 0 && results_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
